[rtl/b64_pkg.sv]
`timescale 1ns / 1ps
// Package for the base64 encoder: the group record passed from the front end
// to the character back end, the padding code and the alphabet lookup.
package b64_pkg;

    localparam logic [7:0] C_PAD_CHAR   = 8'h3D;
    localparam logic [1:0] C_LAST_SLOT  = 2'd3;

    // Count of real bytes in a group, less one.
    typedef enum logic [1:0] {
        GRP_ONE   = 2'd0,
        GRP_TWO   = 2'd1,
        GRP_THREE = 2'd2
    } t_grp_size;

    typedef struct packed {
        logic [23:0] word;
        t_grp_size   size;
        logic        last;
    } t_group;

    // Maps a 6-bit value onto the standard base64 alphabet.
    function automatic logic [7:0] f_b64_char(input logic [5:0] v);
        logic [7:0] wide;
        wide = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + wide;
        end else if (v < 6'd52) begin
            return 8'h61 + wide - 8'd26;
        end else if (v < 6'd62) begin
            return 8'h30 + wide - 8'd52;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

[rtl/b64_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the base64 encoder: the byte input
// channel and the character output channel. No dependencies.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       group_end;
    logic       message_end;

    modport source (output valid, output char_code, output group_end,
                    output message_end, input ready);
    modport sink   (input valid, input char_code, input group_end,
                    input message_end, output ready);
endinterface

[rtl/b64_front.sv]
`timescale 1ns / 1ps
// Front end of the base64 encoder: gathers bytes into groups of up to three.
// Depends on b64_pkg for the group record.
module b64_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic               i_full,
    output logic               o_ready,
    output logic               o_push,
    output b64_pkg::t_group    o_group
);
    import b64_pkg::*;

    logic [15:0] r_pend;
    logic [1:0]  r_cnt;
    logic [15:0] n_pend;
    logic [1:0]  n_cnt;
    logic        w_accept;
    logic        w_hold;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    // The byte only waits when it neither ends the message nor completes a group.
    assign w_hold   = !i_last_byte && (r_cnt != 2'd2);

    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        o_push = 1'b0;
        o_group.last = i_last_byte;
        case (r_cnt)
            2'd0: begin
                o_group.word = {i_data_byte, 16'h0000};
                o_group.size = GRP_ONE;
            end
            2'd1: begin
                o_group.word = {r_pend[15:8], i_data_byte, 8'h00};
                o_group.size = GRP_TWO;
            end
            default: begin
                o_group.word = {r_pend, i_data_byte};
                o_group.size = GRP_THREE;
            end
        endcase
        if (w_accept) begin
            if (w_hold) begin
                if (r_cnt == 2'd0) begin
                    n_pend = {i_data_byte, 8'h00};
                end else begin
                    n_pend = {r_pend[15:8], i_data_byte};
                end
                n_cnt = r_cnt + 2'd1;
            end else begin
                o_push = 1'b1;
                n_pend = 16'h0000;
                n_cnt  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_pend <= 16'h0000;
        end else begin
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
        end
    end

endmodule

[rtl/b64_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue of groups between the front end and the back end.
// Depends on b64_pkg for the group record.
module b64_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b64_pkg::t_group    i_group,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output b64_pkg::t_group    o_group
);
    import b64_pkg::*;

    t_group      r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_group = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/b64_back.sv]
`timescale 1ns / 1ps
// Back end of the base64 encoder: turns a group into four characters, one per
// cycle unless the output stalls, into an output register. Depends on b64_pkg.
module b64_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  b64_pkg::t_group    i_group,
    output logic               o_pop,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [7:0]         o_char_code,
    output logic               o_group_end,
    output logic               o_message_end
);
    import b64_pkg::*;

    t_group      r_grp;
    logic        r_busy;
    logic [1:0]  r_idx;
    logic        r_valid;
    logic [7:0]  r_char;
    logic        r_gend;
    logic        r_mend;
    logic        w_load;
    logic        w_emit;
    logic [5:0]  w_slice;
    logic [7:0]  w_char;
    logic        w_pad;

    // The output register takes a new character whenever it is empty or drained.
    assign w_load = !r_valid || i_ready;
    assign w_emit = r_busy && w_load;
    assign o_pop  = !i_empty && (!r_busy || (w_emit && r_idx == C_LAST_SLOT));

    always_comb begin
        case (r_idx)
            2'd0:    w_slice = r_grp.word[23:18];
            2'd1:    w_slice = r_grp.word[17:12];
            2'd2:    w_slice = r_grp.word[11:6];
            default: w_slice = r_grp.word[5:0];
        endcase
        w_pad  = ((r_idx == 2'd2) && (r_grp.size == GRP_ONE)) ||
                 ((r_idx == C_LAST_SLOT) && (r_grp.size != GRP_THREE));
        w_char = w_pad ? C_PAD_CHAR : f_b64_char(w_slice);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (w_emit) begin
            r_char <= w_char;
            r_gend <= (r_idx == C_LAST_SLOT);
            r_mend <= (r_idx == C_LAST_SLOT) && r_grp.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= w_emit;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (w_emit) begin
                r_idx <= r_idx + 2'd1;
                if (r_idx == C_LAST_SLOT) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_char_code   = r_char;
    assign o_group_end   = r_gend;
    assign o_message_end = r_mend;

endmodule

[rtl/base64_encoder.sv]
`timescale 1ns / 1ps
// Streaming base64 encoder (standard alphabet, '=' padded), top level.
// Depends on b64_pkg, b64_if, b64_front, b64_queue and b64_back.
//
// Channels: i_in carries one message byte per beat with last_byte marking the
// final byte of the message; o_out carries one ASCII character per beat, with
// group_end on the fourth character of each group and message_end on the
// fourth character of the group holding the last byte. Both use valid/ready.
//
// The front end gathers up to two bytes; the third byte, or a byte flagged
// last, closes a group that goes into a two-entry queue. The back end pops a
// group and writes its four characters into the output register, one per
// cycle unless o_out stalls. A group is held in the queue, then in the back
// end's group register, before its characters reach the output register.
//
// Each group yields four characters and the single output register port sets
// the pace; the next group is popped as the last character is emitted.
// Input beats are taken every cycle until the queue holds two groups.
// A synchronous low i_rst_n drops any pending bytes and queued groups.
// When the receiver stalls, the output character holds, the back end waits,
// and the queue then fills so that i_in.ready falls; nothing is lost.
module base64_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64_in_if.sink        i_in,
    b64_out_if.source     o_out
);
    import b64_pkg::*;

    t_group w_front_grp;
    t_group w_queue_grp;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;

    b64_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .i_full      (w_full),
        .o_ready     (i_in.ready),
        .o_push      (w_push),
        .o_group     (w_front_grp)
    );

    b64_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_group (w_front_grp),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_group (w_queue_grp)
    );

    b64_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_group       (w_queue_grp),
        .o_pop         (w_pop),
        .i_ready       (o_out.ready),
        .o_valid       (o_out.valid),
        .o_char_code   (o_out.char_code),
        .o_group_end   (o_out.group_end),
        .o_message_end (o_out.message_end)
    );

endmodule
